>>> src/oss_pkg.sv
// package for the oversampled sensor smoothing block
// types, register codes and fixed-point constants shared by all modules
// no dependencies
package oss_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int CHAN_W    = 3;
    localparam int COUNT_W   = 8;
    localparam int ALPHA_W   = 9;
    localparam int SUM_W     = 20;
    localparam int MILLI_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // iterative divider for the block mean
    localparam int DIV_W     = SUM_W;
    localparam int DIVISOR_W = COUNT_W;

    // division by full scale as a reciprocal multiply: 2^40/4095 rounded up
    // gives the exact floor for every dividend below 2^28
    localparam int PROD_W      = 28;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 40;
    localparam int SCALED_W    = 17;
    localparam logic [RECIP_W-1:0] RECIP_FULL = 29'd268501009;

    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_NUM_CHANNELS         = 5;
    localparam int DEF_NUM_VOLTAGE_CHANNELS = 3;

    localparam logic [COUNT_W-1:0]    RST_SAMPLE_COUNT = 8'd100;
    localparam logic [ALPHA_W-1:0]    RST_ALPHA        = 9'd51;
    localparam logic [SAMPLE_W-1:0]   RST_ZERO_OFFSET  = 12'd1775;

    localparam logic [SAMPLE_W-1:0]   ADC_FULL       = 12'd4095;
    localparam logic [SAMPLE_W-1:0]   ADC_HALF       = 12'd2047;
    localparam logic [15:0]           VOLT_GAIN      = 16'd16764;
    localparam logic [15:0]           CURR_GAIN      = 16'd33000;
    localparam logic [MILLI_W-1:0]    VOLT_OFFSET_MV = 15'd720;
    localparam logic [MILLI_W-1:0]    MILLI_MAX      = 15'd32767;
    localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_ALPHA        = 2'd1,
        CFG_ZERO_OFFSET  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  sample_count;
        logic [ALPHA_W-1:0]  alpha_q8;
        logic [SAMPLE_W-1:0] zero_offset_code;
    } cfg_t;

    // one completed block waiting for the back end
    typedef struct packed {
        logic [CHAN_W-1:0]  channel;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } block_t;

    typedef struct packed {
        logic   push;
        block_t entry;
    } push_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_AVG,
        BK_CONV,
        BK_RECIP,
        BK_SCALE,
        BK_SM1,
        BK_SM2,
        BK_OUT
    } back_state_t;

endpackage

>>> src/oversampled_sensor_smoothing_top.sv
// top level of the oversampled sensor smoothing block
// holds the configuration registers; depends on oss_pkg, oss_front, oss_queue, oss_back
//
// input stream: s_tdata carries one 12-bit adc word, s_tuser its channel. each
// channel sums its samples; after sample_count of them a block is complete and
// is queued for the back end. words on channels at or above NUM_CHANNELS are
// taken and dropped.
// output stream: one word per completed block with channel, mean code and the
// smoothed millivolt or milliamp value. the output register holds the word
// until m_tready; the back end meanwhile starts on the next queued block.
// the completing input word reaches m_tvalid through these steps: the pop
// that starts the bit-serial mean divider, its quotient bits, then the mean
// clamp, the gain product, the multiply by 1/4095, offset and clamp, the two
// smoother steps and the output load. input words are taken one per cycle
// while the two-entry block queue has room; a completed block occupies the
// back end until its output load, so the sustained rate is about one word
// per cycle for large sample_count, while for small sample_count the back
// end limits it. a stalled receiver lets the back end finish one more block,
// then the queue fills and s_tready drops. configuration writes take effect
// on the next edge; the user must make them only while idle, as the block
// itself does not enforce it. reset clears sums, counts, smoothed values and
// the queue, loads the default registers and drops any pending output word.
module oversampled_sensor_smoothing_top
    import oss_pkg::*;
#(
    parameter int NUM_CHANNELS         = DEF_NUM_CHANNELS,
    parameter int NUM_VOLTAGE_CHANNELS = DEF_NUM_VOLTAGE_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample
    input  logic [CHAN_W-1:0]     s_tuser,   // [2:0] channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [11:0] average_code, [26:12] filtered_milli
    output logic [CHAN_W-1:0]     m_tuser,   // [2:0] result_channel
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg_reg;
    push_t               push;
    block_t              head;
    logic                queue_full;
    logic                queue_empty;
    logic                pop;
    logic [SAMPLE_W-1:0] average_code;
    logic [MILLI_W-1:0]  filtered_milli;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_count     <= RST_SAMPLE_COUNT;
            cfg_reg.alpha_q8         <= RST_ALPHA;
            cfg_reg.zero_offset_code <= RST_ZERO_OFFSET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_COUNT: cfg_reg.sample_count     <= cfg_data[COUNT_W-1:0];
                CFG_ALPHA:        cfg_reg.alpha_q8         <= cfg_data[ALPHA_W-1:0];
                CFG_ZERO_OFFSET:  cfg_reg.zero_offset_code <= cfg_data[SAMPLE_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    oss_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .channel    (s_tuser),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push_out   (push)
    );

    oss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .full    (queue_full),
        .empty   (queue_empty),
        .head    (head)
    );

    oss_back #(
        .NUM_CHANNELS         (NUM_CHANNELS),
        .NUM_VOLTAGE_CHANNELS (NUM_VOLTAGE_CHANNELS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .queue_empty    (queue_empty),
        .head           (head),
        .pop            (pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .result_channel (m_tuser),
        .average_code   (average_code),
        .filtered_milli (filtered_milli)
    );

    assign m_tdata = {(M_TDATA_W - SAMPLE_W - MILLI_W)'(0), filtered_milli, average_code};

endmodule

>>> src/oss_front.sv
// front end: accepts samples, keeps per-channel sums and counts
// pushes a completed block into the queue; uses oss_pkg
module oss_front
    import oss_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic [CHAN_W-1:0]     channel,
    input  cfg_t                  cfg,
    input  logic                  queue_full,
    output push_t                 push_out
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [SUM_W-1:0]   sum_reg [NUM_CHANNELS];
    logic [COUNT_W-1:0] cnt_reg [NUM_CHANNELS];

    logic [CH_W-1:0]    ch_idx;
    logic               ch_ok;
    logic               accept;
    logic [COUNT_W-1:0] n_eff;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] cnt_next;
    logic               complete;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign ch_idx   = CH_W'(channel);

    always_comb
    begin
        ch_ok    = (5'(channel) < 5'(NUM_CHANNELS));
        n_eff    = (cfg.sample_count == '0) ? COUNT_W'(1) : cfg.sample_count;
        sum_next = sum_reg[ch_idx] + SUM_W'(sample);
        cnt_next = cnt_reg[ch_idx] + COUNT_W'(1);
        // counter wrap or reaching the (possibly lowered) count ends the block
        complete = (cnt_next == '0) || (cnt_next >= n_eff);

        push_out.push          = accept && ch_ok && complete;
        push_out.entry.channel = channel;
        push_out.entry.sum     = sum_next;
        push_out.entry.count   = n_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (accept && ch_ok)
        begin
            sum_reg[ch_idx] <= complete ? '0 : sum_next;
            cnt_reg[ch_idx] <= complete ? '0 : cnt_next;
        end
    end

endmodule

>>> src/oss_queue.sv
// short queue of completed blocks between front and back end
// register based; uses oss_pkg
module oss_queue
    import oss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push_in,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output block_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    block_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_in.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

>>> src/oss_div.sv
// restoring divider, one quotient bit per cycle
// divides a block sum by the programmed sample count; uses oss_pkg
module oss_div
    import oss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops out
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

endmodule

>>> src/oss_back.sv
// back end: mean, conversion to millis, exponential smoother, output register
// depends on oss_pkg and oss_div
module oss_back
    import oss_pkg::*;
#(
    parameter int NUM_CHANNELS         = DEF_NUM_CHANNELS,
    parameter int NUM_VOLTAGE_CHANNELS = DEF_NUM_VOLTAGE_CHANNELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 queue_empty,
    input  block_t               head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAN_W-1:0]    result_channel,
    output logic [SAMPLE_W-1:0]  average_code,
    output logic [MILLI_W-1:0]   filtered_milli
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    back_state_t          state_reg, state_next;
    logic [CHAN_W-1:0]    ch_reg;
    logic [SAMPLE_W-1:0]  avg_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic [MILLI_W-1:0]   milli_reg;
    logic [23:0]          t1_reg;
    logic [MILLI_W-1:0]   s_reg;
    logic [MILLI_W-1:0]   smooth_reg [NUM_CHANNELS];

    logic                 out_valid_reg;
    logic [CHAN_W-1:0]    out_ch_reg;
    logic [SAMPLE_W-1:0]  out_avg_reg;
    logic [MILLI_W-1:0]   out_milli_reg;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_q;

    logic [CH_W-1:0]      ch_idx;
    logic                 is_volt;
    logic [ALPHA_W-1:0]   a_eff;
    logic [ALPHA_W-1:0]   a_inv;
    logic [SAMPLE_W-1:0]  offset_mag;
    logic [15:0]          gain;
    logic [SAMPLE_W-1:0]  mult_a;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [SCALED_W-1:0]  milli_sum;
    logic [23:0]          acc;
    logic                 out_free;
    logic                 load_out;

    oss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ch_idx         = CH_W'(ch_reg);
    assign m_tvalid       = out_valid_reg;
    assign result_channel = out_ch_reg;
    assign average_code   = out_avg_reg;
    assign filtered_milli = out_milli_reg;
    assign out_free       = !out_valid_reg || m_tready;

    always_comb
    begin
        is_volt    = (5'(ch_reg) < 5'(NUM_VOLTAGE_CHANNELS));
        a_eff      = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
        a_inv      = ALPHA_ONE - a_eff;
        offset_mag = (avg_reg >= cfg.zero_offset_code) ? avg_reg - cfg.zero_offset_code
                                                       : cfg.zero_offset_code - avg_reg;
        mult_a     = is_volt ? avg_reg : offset_mag;
        gain       = is_volt ? VOLT_GAIN : CURR_GAIN;
        recip_prod = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP_FULL);
        milli_sum  = is_volt ? scaled_reg + SCALED_W'(VOLT_OFFSET_MV) : scaled_reg;
        acc        = t1_reg + 24'(a_inv) * 24'(smooth_reg[ch_idx]) + 24'd128;

        state_next   = state_reg;
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIV_W'(head.sum);
        div_divisor  = DIVISOR_W'(head.count);
        load_out     = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    div_start  = 1'b1;
                    state_next = BK_AVG;
                end
            end
            BK_AVG:
            begin
                if (div_done)
                begin
                    state_next = BK_CONV;
                end
            end
            BK_CONV:
            begin
                state_next = BK_RECIP;
            end
            BK_RECIP:
            begin
                state_next = BK_SCALE;
            end
            BK_SCALE:
            begin
                state_next = BK_SM1;
            end
            BK_SM1:
            begin
                state_next = BK_SM2;
            end
            BK_SM2:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE)
        begin
            ch_reg <= head.channel;
        end
        if (state_reg == BK_AVG && div_done)
        begin
            // a lowered count can push the mean past full scale
            avg_reg <= (div_q > DIV_W'(ADC_FULL)) ? ADC_FULL : div_q[SAMPLE_W-1:0];
        end
        if (state_reg == BK_CONV)
        begin
            prod_reg <= PROD_W'(mult_a) * PROD_W'(gain) + PROD_W'(ADC_HALF);
        end
        if (state_reg == BK_RECIP)
        begin
            // floor of the product over full scale
            scaled_reg <= recip_prod[RECIP_SHIFT +: SCALED_W];
        end
        if (state_reg == BK_SCALE)
        begin
            milli_reg <= (milli_sum > SCALED_W'(MILLI_MAX)) ? MILLI_MAX
                                                            : milli_sum[MILLI_W-1:0];
        end
        if (state_reg == BK_SM1)
        begin
            t1_reg <= 24'(a_eff) * 24'(milli_reg);
        end
        if (state_reg == BK_SM2)
        begin
            s_reg <= (acc[23:8] > 16'(MILLI_MAX)) ? MILLI_MAX : acc[8 +: MILLI_W];
        end
        if (load_out)
        begin
            out_ch_reg    <= ch_reg;
            out_avg_reg   <= avg_reg;
            out_milli_reg <= s_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                smooth_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg      <= 1'b1;
                smooth_reg[ch_idx] <= s_reg;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> src/oss_checker.sv
// port-level checks for the oversampled sensor smoothing block
// bound to oversampled_sensor_smoothing_top; uses oss_pkg
module oss_port_checks
    import oss_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [CHAN_W-1:0]    m_tuser
);

    // a stalled word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // results only for existing channels
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (5'(m_tuser) < 5'(NUM_CHANNELS)))
        else $error("result channel out of range");

    // padding above the two data fields stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:SAMPLE_W+MILLI_W] == '0))
        else $error("output padding not zero");

    // reset drops the pending word
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind oversampled_sensor_smoothing_top oss_port_checks #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_oss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
